>>> rtl/rilbp_pkg.sv
// ----------------------------------------------------------------------------
// rilbp_pkg
// Shared types, constants and helper functions for the rotation-invariant
// circular LBP block (radius 3, eight points).
// ----------------------------------------------------------------------------
package rilbp_pkg;

  // Window geometry: 7x7 neighborhood, six stored lines.
  localparam int WIN        = 7;
  localparam int STORE_ROWS = 6;
  localparam int RADIUS     = 3;
  localparam int FIRST_OUT  = 2 * RADIUS;

  // Frame size limits.
  localparam int MIN_SIZE   = 7;
  localparam int MAX_HEIGHT = 4096;

  // Configuration register indexes.
  localparam int          CFG_INDEX_W      = 2;
  localparam logic [1:0]  REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0]  REG_IMAGE_HEIGHT = 2'd1;
  localparam int          CFG_DATA_W       = 13;

  // Bilinear weights for the diagonal samples in 0.8 fixed point (sum 256).
  localparam int W_NEAR = 198;
  localparam int W_SIDE = 27;
  localparam int W_FAR  = 4;

  typedef logic [7:0] pix_t;

  // One column entering the window: index 0 is the oldest line.
  typedef pix_t [WIN-1:0] column_t;

  // One line-store word: the six stored pixels of one column.
  typedef pix_t [STORE_ROWS-1:0] store_word_t;

  // Per-item control that travels down the pipeline.
  typedef struct packed {
    logic produce;
    logic eol;
    logic eof;
  } item_flags_t;

  // Weighted sum of the four corners around one diagonal sample point.
  function automatic logic [15:0] diag_sample(pix_t near_px, pix_t side_a,
                                              pix_t side_b, pix_t far_px);
    logic [15:0] acc;
    acc = 16'(near_px) * 16'(W_NEAR)
        + 16'(side_a) * 16'(W_SIDE)
        + 16'(side_b) * 16'(W_SIDE)
        + 16'(far_px) * 16'(W_FAR);
    return acc;
  endfunction

  // Smallest of the eight rotations of an 8-bit code.
  function automatic pix_t rot_min(pix_t code);
    pix_t        best;
    pix_t        rot;
    logic [15:0] dbl;
    best = code;
    dbl  = {code, code};
    for (int r = 1; r < 8; r++) begin
      rot = 8'(dbl >> (8 - r));
      if (rot < best) begin
        best = rot;
      end
    end
    return best;
  endfunction

endpackage

>>> rtl/rilbp_line_store.sv
// ----------------------------------------------------------------------------
// rilbp_line_store
// Six line buffers packed into one word per column, one read and one write
// port, registered read data.
// ----------------------------------------------------------------------------
module rilbp_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output rilbp_pkg::store_word_t rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  rilbp_pkg::store_word_t wr_data
);

  rilbp_pkg::store_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/rilbp_window.sv
// ----------------------------------------------------------------------------
// rilbp_window
// 7x7 window of pixel registers and the eight-point circular comparison that
// forms the raw pattern around the window center.
// ----------------------------------------------------------------------------
module rilbp_window (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  rilbp_pkg::column_t column,
  output rilbp_pkg::pix_t    raw_code
);

  localparam int W = rilbp_pkg::WIN;

  rilbp_pkg::pix_t win [W][W];
  logic [15:0]     center_fx;

  // Each row shifts left by one; the new column enters on the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < W; r++) begin
        for (int c = 0; c < W; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (shift) begin
      for (int r = 0; r < W; r++) begin
        for (int c = 0; c < W - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
        win[r][W-1] <= column[r];
      end
    end
  end

  assign center_fx = {win[3][3], 8'h00};

  // Sample k sets bit 7-k. Cardinal points compare a single pixel directly.
  always_comb begin
    raw_code[7] = win[6][3] > win[3][3];
    raw_code[6] = rilbp_pkg::diag_sample(win[5][1], win[5][0], win[6][1], win[6][0])
                  > center_fx;
    raw_code[5] = win[3][0] > win[3][3];
    raw_code[4] = rilbp_pkg::diag_sample(win[1][1], win[1][0], win[0][1], win[0][0])
                  > center_fx;
    raw_code[3] = win[0][3] > win[3][3];
    raw_code[2] = rilbp_pkg::diag_sample(win[1][5], win[1][6], win[0][5], win[0][6])
                  > center_fx;
    raw_code[1] = win[3][6] > win[3][3];
    raw_code[0] = rilbp_pkg::diag_sample(win[5][5], win[5][6], win[6][5], win[6][6])
                  > center_fx;
  end

endmodule

>>> rtl/rotation_invariant_circular_lbp.sv
// A pixel moves through stage 1, the window, stage 3 and the output register, in that order.
// Throughput: one pixel per cycle unless stalled; one line store read and write per pixel.
// No code is centered on the three-pixel frame border; those pixels are still consumed.
// Reset (rst, synchronous, active high) clears counters, window and pipeline valids,
// and sets image_width to 24 and image_height to 12. Line store contents are not cleared.
// ----------------------------------------------------------------------------
// rotation_invariant_circular_lbp
// Radius-3, eight-point rotation-invariant local binary pattern over a raster
// pixel stream, built around a column-wide line store and a 7x7 window.
// ----------------------------------------------------------------------------
module rotation_invariant_circular_lbp #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rilbp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rilbp_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Pixel input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          gray_pixel,
  // Code output channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          lbp_code,
  output logic                                end_of_row,
  output logic                                end_of_frame
);

  // Column address width; the column count never reaches MAX_LINE_WIDTH.
  localparam int CW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;

  // Configuration registers. Writes are always accepted.
  logic [10:0] image_width;
  logic [12:0] image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd24;
      image_height <= 13'd12;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rilbp_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        rilbp_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Sizes in use are clamped to the supported range.
  logic [12:0] width_eff;
  logic [12:0] height_eff;

  always_comb begin
    if ({2'b00, image_width} < 13'(rilbp_pkg::MIN_SIZE)) begin
      width_eff = 13'(rilbp_pkg::MIN_SIZE);
    end else if ({2'b00, image_width} > 13'(MAX_LINE_WIDTH)) begin
      width_eff = 13'(MAX_LINE_WIDTH);
    end else begin
      width_eff = {2'b00, image_width};
    end
    if (image_height < 13'(rilbp_pkg::MIN_SIZE)) begin
      height_eff = 13'(rilbp_pkg::MIN_SIZE);
    end else if (image_height > 13'(rilbp_pkg::MAX_HEIGHT)) begin
      height_eff = 13'(rilbp_pkg::MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  // Pipeline handshake. Each stage moves when the stage after it is empty or
  // moving, so bubbles collapse and the input keeps flowing while a finished
  // code waits in the output register, until the stages behind it fill up.
  logic v1, v2, v3;
  logic s4_take, s3_free, s2_free, s1_free;
  logic in_fire, adv1, ld3, ld4;

  assign s4_take  = !out_valid || out_ready;
  assign s3_free  = !v3 || s4_take;
  assign s2_free  = !v2 || s3_free;
  assign s1_free  = !v1 || s2_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && in_ready;
  assign adv1     = v1 && s2_free;
  assign ld3      = v2 && s3_free;
  assign ld4      = v3 && s4_take;

  // Raster position of the next pixel and the flags for the pixel arriving now.
  logic [CW-1:0]          column_count;
  logic [11:0]            row_count;
  logic [12:0]            col_plus;
  logic [12:0]            row_plus;
  rilbp_pkg::item_flags_t in_flags;

  assign col_plus         = 13'(column_count) + 13'd1;
  assign row_plus         = 13'(row_count) + 13'd1;
  assign in_flags.eol     = col_plus >= width_eff;
  assign in_flags.eof     = in_flags.eol && (row_plus >= height_eff);
  assign in_flags.produce = (13'(column_count) >= 13'(rilbp_pkg::FIRST_OUT))
                         && (13'(row_count) >= 13'(rilbp_pkg::FIRST_OUT));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (in_flags.eol) begin
        column_count <= '0;
        row_count    <= in_flags.eof ? 12'd0 : row_plus[11:0];
      end else begin
        column_count <= col_plus[CW-1:0];
      end
    end
  end

  // Stage 1: the line store read for the accepted pixel's column is in flight.
  logic [CW-1:0]          s1_col;
  rilbp_pkg::pix_t        s1_pix;
  rilbp_pkg::item_flags_t s1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_free) begin
      v1 <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col   <= column_count;
      s1_pix   <= gray_pixel;
      s1_flags <= in_flags;
    end
  end

  // Line store: the stored column plus the new pixel form the window column,
  // and the column moves up one line on write-back. A column is revisited no
  // sooner than a full line later, so read and write never meet on one entry.
  rilbp_pkg::store_word_t rd_word;
  rilbp_pkg::store_word_t wr_word;
  rilbp_pkg::column_t     win_column;

  always_comb begin
    for (int i = 0; i < rilbp_pkg::STORE_ROWS; i++) begin
      win_column[i] = rd_word[i];
    end
    win_column[rilbp_pkg::WIN-1] = s1_pix;
    for (int i = 0; i < rilbp_pkg::STORE_ROWS; i++) begin
      wr_word[i] = win_column[i+1];
    end
  end

  rilbp_line_store #(
    .DEPTH (MAX_LINE_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (column_count),
    .rd_data (rd_word),
    .wr_en   (adv1),
    .wr_addr (s1_col),
    .wr_data (wr_word)
  );

  // Stage 2: the window holds the neighborhood of this item's center.
  rilbp_pkg::item_flags_t s2_flags;
  rilbp_pkg::pix_t        raw_code;

  rilbp_window u_window (
    .clk      (clk),
    .rst      (rst),
    .shift    (adv1),
    .column   (win_column),
    .raw_code (raw_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_free) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_flags <= s1_flags;
    end
  end

  // Stage 3: raw pattern registered. Border items are dropped here.
  rilbp_pkg::pix_t s3_code;
  logic            s3_eol;
  logic            s3_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (s3_free) begin
      v3 <= v2 && s2_flags.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_code <= raw_code;
      s3_eol  <= s2_flags.eol;
      s3_eof  <= s2_flags.eof;
    end
  end

  // Stage 4: rotation minimum into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s4_take) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      lbp_code     <= rilbp_pkg::rot_min(s3_code);
      end_of_row   <= s3_eol;
      end_of_frame <= s3_eof;
    end
  end

`ifndef SYNTHESIS
  // The line store never reads and writes one column in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    !(in_fire && adv1 && (column_count == s1_col)))
    else $error("line store read and write collide on one column");

  // The last code of a frame is always the last code of its row.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!end_of_frame || end_of_row))
    else $error("end_of_frame without end_of_row");

  // An accepted pixel always occupies the first stage on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> v1)
    else $error("accepted pixel lost before the line store read");

  // A code reaches the output register only from a filled third stage.
  assert property (@(posedge clk) disable iff (rst)
    (s4_take && !v3) |=> !out_valid)
    else $error("output valid without a code behind it");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the radius-3, eight-point rotation-invariant LBP block. A
// table of small directed frames comes first, then random frames of random
// size, some of them resized part way through. Every code the block emits is
// compared with a typed table code or a cycle-free software copy in this file.
// ----------------------------------------------------------------------------
module testbench;

  // Line store depth used by the instance and by the local prediction.
  localparam int LINE_MAX = 1024;

  // Least number of random pixels to send after the directed table.
  localparam int RANDOM_PIXELS = 80;

  // Cycles to let pass after the last expected code before touching the
  // size registers. Border pixels still in flight produce no code, so the
  // pipeline depth plus some margin is allowed for them.
  localparam int SETTLE_CYCLES = 8;

  // One code as the block presents it on its output channel.
  typedef struct packed {
    rilbp_pkg::pix_t code;
    logic            eor;
    logic            eof;
  } lbp_result_t;

  // How the pixels of one frame are made up.
  typedef enum logic [1:0] {
    FILL_FLAT,   // every pixel takes the background value
    FILL_DOT,    // background with one foreground pixel at a fixed spot
    FILL_NOISE,  // uniform random gray levels
    FILL_FAINT   // background plus or minus a few levels, so many ties occur
  } fill_e;

  // A pause part way through a frame: after this many pixels the block is
  // left to drain and both size registers are loaded with the given values.
  typedef struct packed {
    logic [15:0] count;
    logic [10:0] width_val;
    logic [12:0] height_val;
  } pause_t;

  // One row of the directed table: the sizes to load (if any), the frame
  // contents, and, for the single-code 7x7 frames whose answer is obvious,
  // the code that must come out.
  typedef struct packed {
    logic            set_size;
    logic [10:0]     width_val;
    logic [12:0]     height_val;
    fill_e           fill;
    rilbp_pkg::pix_t fg;
    rilbp_pkg::pix_t bg;
    logic [3:0]      dot_r;
    logic [3:0]      dot_c;
    logic            typed;
    lbp_result_t     want;
    pause_t          pause;
  } plan_row_t;

  localparam logic [3:0]  NO_DOT    = 4'hF;
  localparam lbp_result_t NO_CHECK  = '0;
  localparam pause_t      NO_PAUSE  = '0;
  // A 7x7 frame yields exactly one code, which closes both its row and frame.
  localparam lbp_result_t LONE_ZERO = '{8'h00, 1'b1, 1'b1};
  localparam lbp_result_t LONE_ONE  = '{8'h01, 1'b1, 1'b1};
  localparam lbp_result_t LONE_FULL = '{8'hFF, 1'b1, 1'b1};

  localparam int PLAN_LEN = 16;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // Sizes left at their reset values (24 x 12). Early in the seventh line
    // the frame is narrowed to 7, which closes that line at once; five more
    // lines then reach the reset height.
    '{1'b0, 11'd0, 13'd0, FILL_NOISE, 8'd0, 8'd0, NO_DOT, NO_DOT, 1'b0, NO_CHECK,
      '{16'd151, 11'd7, 13'd12}},
    // Bright center over black and dark center over white.
    '{1'b1, 11'd7, 13'd7, FILL_DOT, 8'd255, 8'd0, 4'd3, 4'd3, 1'b1, LONE_ZERO, NO_PAUSE},
    '{1'b1, 11'd7, 13'd7, FILL_DOT, 8'd0, 8'd255, 4'd3, 4'd3, 1'b1, LONE_FULL, NO_PAUSE},
    // Sizes below the minimum are raised to 7. A flat frame ties everywhere.
    '{1'b1, 11'd0, 13'd0, FILL_FLAT, 8'd0, 8'd128, NO_DOT, NO_DOT, 1'b1, LONE_ZERO, NO_PAUSE},
    '{1'b1, 11'd6, 13'd6, FILL_DOT, 8'd0, 8'd1, 4'd3, 4'd3, 1'b1, LONE_FULL, NO_PAUSE},
    // One bright pixel on each cardinal point sets a single bit.
    '{1'b1, 11'd7, 13'd7, FILL_DOT, 8'd255, 8'd0, 4'd6, 4'd3, 1'b1, LONE_ONE, NO_PAUSE},
    '{1'b1, 11'd7, 13'd7, FILL_DOT, 8'd255, 8'd0, 4'd3, 4'd0, 1'b1, LONE_ONE, NO_PAUSE},
    '{1'b1, 11'd7, 13'd7, FILL_DOT, 8'd255, 8'd0, 4'd0, 4'd3, 1'b1, LONE_ONE, NO_PAUSE},
    '{1'b1, 11'd7, 13'd7, FILL_DOT, 8'd255, 8'd0, 4'd3, 4'd6, 1'b1, LONE_ONE, NO_PAUSE},
    // A level of one on the near, far or side corner of a diagonal point
    // already lifts that sample above a black center.
    '{1'b1, 11'd7, 13'd7, FILL_DOT, 8'd1, 8'd0, 4'd1, 4'd1, 1'b1, LONE_ONE, NO_PAUSE},
    '{1'b1, 11'd7, 13'd7, FILL_DOT, 8'd1, 8'd0, 4'd0, 4'd0, 1'b1, LONE_ONE, NO_PAUSE},
    '{1'b1, 11'd7, 13'd7, FILL_DOT, 8'd1, 8'd0, 4'd1, 4'd0, 1'b1, LONE_ONE, NO_PAUSE},
    // A pixel inside the circle that no sample touches.
    '{1'b1, 11'd7, 13'd7, FILL_DOT, 8'd255, 8'd0, 4'd2, 4'd3, 1'b1, LONE_ZERO, NO_PAUSE},
    // From here on the codes are predicted.
    // One all-ones register value per frame: the width clamps to the line store,
    // the height to 4096. Both frames are cut short by a resize part way through.
    '{1'b1, 11'd2047, 13'd0, FILL_NOISE, 8'd0, 8'd0, NO_DOT, NO_DOT, 1'b0, NO_CHECK,
      '{16'd40, 11'd7, 13'd7}},
    '{1'b1, 11'd7, 13'd8191, FILL_NOISE, 8'd0, 8'd0, NO_DOT, NO_DOT, 1'b0, NO_CHECK,
      '{16'd70, 11'd7, 13'd7}},
    // Near-white noise that saturates at the top gray level.
    '{1'b1, 11'd7, 13'd7, FILL_FAINT, 8'd0, 8'd255, NO_DOT, NO_DOT, 1'b0, NO_CHECK, NO_PAUSE}
  };

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs. Every input has a known value at time 0.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [rilbp_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [rilbp_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

  logic            in_valid   = 1'b0;
  logic            in_ready;
  rilbp_pkg::pix_t gray_pixel = '0;

  logic            out_valid;
  logic            out_ready  = 1'b0;
  rilbp_pkg::pix_t lbp_code;
  logic            end_of_row;
  logic            end_of_frame;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rotation_invariant_circular_lbp #(
    .MAX_LINE_WIDTH(LINE_MAX)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .gray_pixel  (gray_pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .lbp_code    (lbp_code),
    .end_of_row  (end_of_row),
    .end_of_frame(end_of_frame)
  );

  // --------------------------------------------------------------------------
  // Software copy of the block. It advances once per accepted pixel and keeps
  // its own line store, window, raster position and size registers.
  // --------------------------------------------------------------------------
  rilbp_pkg::pix_t line_mem [rilbp_pkg::STORE_ROWS][LINE_MAX];
  rilbp_pkg::pix_t window [rilbp_pkg::WIN][rilbp_pkg::WIN];
  int              pos_col    = 0;
  int              pos_row    = 0;
  logic [10:0]     width_reg  = 11'd24;
  logic [12:0]     height_reg = 13'd12;

  // Codes predicted but not yet seen on the output, oldest first.
  lbp_result_t pending_codes [$];

  // When set, the directed row supplies the expected code itself.
  logic        typed_on   = 1'b0;
  lbp_result_t typed_want = '0;

  int failures = 0;

  // Sender burst bookkeeping: items left in the current burst.
  int burst_left = 0;

  initial begin
    for (int i = 0; i < rilbp_pkg::STORE_ROWS; i++) begin
      for (int j = 0; j < LINE_MAX; j++) begin
        line_mem[i][j] = '0;
      end
    end
    for (int i = 0; i < rilbp_pkg::WIN; i++) begin
      for (int j = 0; j < rilbp_pkg::WIN; j++) begin
        window[i][j] = '0;
      end
    end
  end

  // Size registers as the block uses them, raised to the minimum and capped.
  function automatic int eff_size(int v, int hi);
    if (v < rilbp_pkg::MIN_SIZE) begin
      return rilbp_pkg::MIN_SIZE;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Bilinear value of one diagonal sample in 0.8 fixed point.
  function automatic int corner_blend(rilbp_pkg::pix_t near_px, rilbp_pkg::pix_t side_a,
                                      rilbp_pkg::pix_t side_b, rilbp_pkg::pix_t far_px);
    return int'(near_px) * rilbp_pkg::W_NEAR
         + (int'(side_a) + int'(side_b)) * rilbp_pkg::W_SIDE
         + int'(far_px) * rilbp_pkg::W_FAR;
  endfunction

  // Code of the current window: bit 7-k is set when sample k is brighter
  // than the center, then the smallest rotation of the pattern is kept.
  function automatic rilbp_pkg::pix_t circle_code();
    int              samp [8];
    int              ctr;
    rilbp_pkg::pix_t bits;
    rilbp_pkg::pix_t best;
    rilbp_pkg::pix_t rot;
    ctr     = int'(window[3][3]) * 256;
    // Cardinal points fall on whole pixels.
    samp[0] = int'(window[6][3]) * 256;
    samp[2] = int'(window[3][0]) * 256;
    samp[4] = int'(window[0][3]) * 256;
    samp[6] = int'(window[3][6]) * 256;
    // Diagonal points sit between four pixels; the near one is listed first.
    samp[1] = corner_blend(window[5][1], window[5][0], window[6][1], window[6][0]);
    samp[3] = corner_blend(window[1][1], window[1][0], window[0][1], window[0][0]);
    samp[5] = corner_blend(window[1][5], window[1][6], window[0][5], window[0][6]);
    samp[7] = corner_blend(window[5][5], window[5][6], window[6][5], window[6][6]);
    for (int k = 0; k < 8; k++) begin
      bits[7-k] = (samp[k] > ctr);
    end
    best = bits;
    rot  = bits;
    for (int r = 1; r < 8; r++) begin
      rot = {rot[6:0], rot[7]};
      if (rot < best) begin
        best = rot;
      end
    end
    return best;
  endfunction

  // Advances the copy by one accepted pixel and queues the code it causes.
  task automatic predict_pixel(input rilbp_pkg::pix_t px);
    int              w;
    int              h;
    int              slot;
    rilbp_pkg::pix_t column [rilbp_pkg::WIN];
    logic            last_col;
    logic            last_row;
    lbp_result_t     res;
    w    = eff_size(int'(width_reg), LINE_MAX);
    h    = eff_size(int'(height_reg), rilbp_pkg::MAX_HEIGHT);
    slot = pos_col % LINE_MAX;
    // Read the six stored lines of this column, push the new pixel in at
    // the bottom and write the column back shifted up by one line.
    for (int i = 0; i < rilbp_pkg::STORE_ROWS; i++) begin
      column[i] = line_mem[i][slot];
    end
    column[rilbp_pkg::WIN-1] = px;
    for (int i = 0; i < rilbp_pkg::STORE_ROWS; i++) begin
      line_mem[i][slot] = column[i+1];
    end
    // The window moves one column to the right.
    for (int i = 0; i < rilbp_pkg::WIN; i++) begin
      for (int j = 0; j < rilbp_pkg::WIN - 1; j++) begin
        window[i][j] = window[i][j+1];
      end
      window[i][rilbp_pkg::WIN-1] = column[i];
    end
    last_col = (pos_col + 1 >= w);
    last_row = last_col && (pos_row + 1 >= h);
    if (pos_col >= rilbp_pkg::FIRST_OUT && pos_row >= rilbp_pkg::FIRST_OUT) begin
      res = '{circle_code(), last_col, last_row};
      if (typed_on) begin
        res = typed_want;
      end
      pending_codes.insert(pending_codes.size(), res);
    end
    if (last_col) begin
      pos_col = 0;
      pos_row = last_row ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Writes one size register and mirrors it into the local copy. The channel
  // is released for a cycle so back-to-back writes never fold into one step.
  task automatic write_reg(input logic [rilbp_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[rilbp_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == rilbp_pkg::REG_IMAGE_WIDTH) begin
      width_reg = val[10:0];
    end else begin
      height_reg = val[12:0];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted code has come out, then lets the border
  // pixels still in the pipeline drain, so the block is idle afterwards.
  task automatic settle();
    while (pending_codes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Gray level for the next pixel, chosen from its place in the frame.
  function automatic rilbp_pkg::pix_t pick_pixel(fill_e fill, rilbp_pkg::pix_t fg,
                                                 rilbp_pkg::pix_t bg,
                                                 logic [3:0] dot_r, logic [3:0] dot_c);
    int v;
    case (fill)
      FILL_FLAT: begin
        return bg;
      end
      FILL_DOT: begin
        return (pos_row == int'(dot_r) && pos_col == int'(dot_c)) ? fg : bg;
      end
      FILL_FAINT: begin
        v = int'(bg) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) begin
          v = 0;
        end
        if (v > 255) begin
          v = 255;
        end
        return rilbp_pkg::pix_t'(v);
      end
      default: begin
        return rilbp_pkg::pix_t'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // Offers one pixel until it is taken, then either keeps valid high for the
  // next item of the burst or drops it for a gap of random length.
  task automatic push_pixel(input rilbp_pkg::pix_t px);
    in_valid   <= 1'b1;
    gray_pixel <= px;
    do @(posedge clk); while (!in_ready);
    predict_pixel(px);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // Now and then a long burst, so that stretches without gaps occur.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 31);
    end
  endtask

  // Sends pixels until the frame closes or the given number has been sent.
  task automatic stream_pixels(input fill_e fill, input rilbp_pkg::pix_t fg,
                               input rilbp_pkg::pix_t bg,
                               input logic [3:0] dot_r, input logic [3:0] dot_c,
                               input int limit, output int sent);
    sent = 0;
    do begin
      push_pixel(pick_pixel(fill, fg, bg, dot_r, dot_c));
      sent++;
    end while (!(pos_col == 0 && pos_row == 0) && sent < limit);
    in_valid <= 1'b0;
  endtask

  // Random register value: mostly a small legal size, sometimes one below
  // the minimum so that the clamp keeps being exercised.
  function automatic int unsigned pick_size(int unsigned top);
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, rilbp_pkg::MIN_SIZE - 1);
    end
    return $urandom_range(rilbp_pkg::MIN_SIZE, top);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: out_ready follows a pattern of its own that changes at random
  // intervals: always ready, a coin toss per cycle, or runs of ready and
  // stall of random length.
  // --------------------------------------------------------------------------
  int   rx_left  = 0;
  int   rx_mode  = 0;
  int   rx_run   = 0;
  logic rx_level = 1'b1;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (rx_run == 0) begin
          rx_level = !rx_level;
          rx_run   = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 8);
        end
        rx_run--;
        out_ready <= rx_level;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output check: every accepted code is matched with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_codes
    lbp_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected code %0h (end_of_row %0b, end_of_frame %0b)",
               lbp_code, end_of_row, end_of_frame);
        failures++;
      end else begin
        want = pending_codes.pop_front();
        if (lbp_code !== want.code) begin
          $error("lbp_code: expected %0h, got %0h", want.code, lbp_code);
          failures++;
        end
        if (end_of_row !== want.eor) begin
          $error("end_of_row: expected %0b, got %0b", want.eor, end_of_row);
          failures++;
        end
        if (end_of_frame !== want.eof) begin
          $error("end_of_frame: expected %0b, got %0b", want.eof, end_of_frame);
          failures++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int              sent;
    int              more;
    int              random_sent;
    int              w_eff;
    int              h_eff;
    int              stop_at;
    fill_e           fill;
    rilbp_pkg::pix_t base;
    random_sent = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Each row is one complete frame, loaded while idle. A
    // row with a pause is resized while idle part way through its frame.
    for (int n = 0; n < PLAN_LEN; n++) begin
      if (PLAN[n].set_size) begin
        write_reg(rilbp_pkg::REG_IMAGE_WIDTH, 32'(PLAN[n].width_val));
        write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, 32'(PLAN[n].height_val));
      end
      typed_on   = PLAN[n].typed;
      typed_want = PLAN[n].want;
      if (PLAN[n].pause.count != '0) begin
        stream_pixels(PLAN[n].fill, PLAN[n].fg, PLAN[n].bg, PLAN[n].dot_r, PLAN[n].dot_c,
                      int'(PLAN[n].pause.count), sent);
        settle();
        write_reg(rilbp_pkg::REG_IMAGE_WIDTH, 32'(PLAN[n].pause.width_val));
        write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, 32'(PLAN[n].pause.height_val));
        stream_pixels(PLAN[n].fill, PLAN[n].fg, PLAN[n].bg, PLAN[n].dot_r, PLAN[n].dot_c,
                      32'h7FFF_FFFF, more);
      end else begin
        stream_pixels(PLAN[n].fill, PLAN[n].fg, PLAN[n].bg, PLAN[n].dot_r, PLAN[n].dot_c,
                      32'h7FFF_FFFF, sent);
      end
      settle();
    end
    typed_on = 1'b0;

    // Random frames of small random size. Each frame starts at the top left
    // corner, so every line-store column it reads has been filled during the
    // frame's first six lines.
    while (random_sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) != 0) begin
        write_reg(rilbp_pkg::REG_IMAGE_WIDTH, pick_size(16));
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, pick_size(12));
      end
      w_eff = eff_size(int'(width_reg), LINE_MAX);
      h_eff = eff_size(int'(height_reg), rilbp_pkg::MAX_HEIGHT);
      fill  = ($urandom_range(0, 3) == 0) ? FILL_FAINT : FILL_NOISE;
      base  = rilbp_pkg::pix_t'($urandom_range(0, 255));

      // Half of the frames are paused part way and resized while idle. The
      // height may change freely; the width only shrinks, which keeps every
      // column the rest of the frame reads among those already filled. A
      // column count past the new last column closes the line at once.
      stop_at = w_eff * h_eff;
      if ($urandom_range(0, 1) == 1) begin
        stop_at = $urandom_range(1, w_eff * h_eff - 1);
      end
      stream_pixels(fill, 8'd0, base, NO_DOT, NO_DOT, stop_at, sent);
      random_sent += sent;
      if (!(pos_col == 0 && pos_row == 0)) begin
        settle();
        if ($urandom_range(0, 2) != 0) begin
          write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, pick_size(14));
        end
        if ($urandom_range(0, 1) == 1) begin
          write_reg(rilbp_pkg::REG_IMAGE_WIDTH, $urandom_range(rilbp_pkg::MIN_SIZE, w_eff));
        end
        stream_pixels(fill, 8'd0, base, NO_DOT, NO_DOT, 32'h7FFF_FFFF, more);
        random_sent += more;
      end
      settle();
    end

    // All pixels are in and every code has been seen; settle() also waited
    // out the pipeline so a late stray code would have been caught.
    if (pending_codes.size() != 0) begin
      $error("%0d predicted codes never came out", pending_codes.size());
    end
    if (failures == 0 && pending_codes.size() == 0) begin
      $display("rotation_invariant_circular_lbp regression: pass");
    end else begin
      $display("rotation_invariant_circular_lbp regression: fail");
    end
    $finish;
  end

  // Watchdog: the slowest legal run takes well under a tenth of this.
  initial begin
    #40_000_000;
    $display("rotation_invariant_circular_lbp regression: fail");
    $finish;
  end

endmodule

>>> rotation_invariant_circular_lbp.f
rtl/rilbp_pkg.sv
rtl/rilbp_line_store.sv
rtl/rilbp_window.sv
rtl/rotation_invariant_circular_lbp.sv
test/testbench.sv
